[hdl/multi_channel_pipe_fifo_top_defines.svh]
// ============================================================================
// multi_channel_pipe_fifo_top_defines.svh - assertion macros
// Shared property shapes for the pipe FIFO checkers.
// ============================================================================
`ifndef MULTI_CHANNEL_PIPE_FIFO_TOP_DEFINES_SVH
`define MULTI_CHANNEL_PIPE_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, gated by reset
`define MCPF_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mcpf check failed: %m");

// Next-cycle implication, gated by reset
`define MCPF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mcpf check failed: %m");

`endif

[hdl/mcpf_pkg.sv]
// ============================================================================
// mcpf_pkg - shared types and constants
// Channel and pipe sizing, request and status codes, per-channel record.
// ============================================================================
package mcpf_pkg;

    localparam int CHAN_COUNT  = 16;
    localparam int PIPE_BYTES  = 1024;
    localparam int CHAN_W      = $clog2(CHAN_COUNT);
    localparam int PTR_W       = $clog2(PIPE_BYTES);
    localparam int FILL_W      = $clog2(PIPE_BYTES + 1);
    localparam int STORE_DEPTH = CHAN_COUNT * PIPE_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int REQ_W    = 3;
    localparam int STATUS_W = 3;
    localparam int FIELD_CH_W = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_OPEN  = 3'd0,
        REQ_CLOSE = 3'd1,
        REQ_WRITE = 3'd2,
        REQ_READ  = 3'd3,
        REQ_EOF   = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_BAD   = 3'd1,
        ST_FULL  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_EOF   = 3'd4,
        ST_ENDED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_BYTE
    } state_t;

    // Per-channel pointer record held in the metadata RAM
    typedef struct packed {
        logic              eof;
        logic [PTR_W-1:0]  rd_ptr;
        logic [PTR_W-1:0]  wr_ptr;
        logic [FILL_W-1:0] fill;
    } meta_t;

    // Step a ring pointer, wrapping at the pipe size
    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(PIPE_BYTES - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

[hdl/mcpf_ram.sv]
// ============================================================================
// mcpf_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
module mcpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/multi_channel_pipe_fifo_top.sv]
// ============================================================================
// multi_channel_pipe_fifo_top - bank of byte pipes with end-of-file marking
// Serves open, close, write, read and eof requests, one result per item.
// ============================================================================
//
//  channel | dir | tuser              | tdata
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | req_type [2:0]     | channel[3:0] in_byte[11:4] consume[12] first[13]
//  m_      | out | status [2:0]       | opened_channel[3:0] out_byte[11:4]
//
//  An item reads the channel's pointer record from the metadata RAM, then
//  updates it and touches the byte store; a read that takes a byte then
//  waits in a further state for the byte store's registered read.
//  Reset clears the state machine, the open/mode bits (channels 0 and 1 open
//  in consuming mode) and the record valid bits; no clearing pass.
//  A stalled result holds the sequencer; s_tready is high in idle only.
//
module multi_channel_pipe_fifo_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    input  logic [15:0] s_tdata,   // channel[3:0], in_byte[11:4], consume_mode[12],
                                   // first_byte[13], zero[15:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic [15:0] m_tdata    // opened_channel[3:0], out_byte[11:4], zero[15:12]
);

    import mcpf_pkg::*;

    state_t state_reg, state_next;

    // Item captured at accept
    req_t                  req_reg;
    logic [FIELD_CH_W-1:0] ch_reg;
    logic [7:0]            wbyte_reg;
    logic                  cons_reg;
    logic                  first_reg;
    logic                  meta_hit_reg;

    // Per-channel flags
    logic [CHAN_COUNT-1:0] open_reg,  open_next;
    logic [CHAN_COUNT-1:0] mode_reg,  mode_next;
    logic [CHAN_COUNT-1:0] mvld_reg,  mvld_next;

    // Result register
    logic       m_tvalid_reg;
    status_t    status_reg;
    logic [3:0] opened_reg;
    logic [7:0] rbyte_reg;

    logic s_fire;
    logic out_free;
    logic exec_fire;
    logic byte_fire;

    logic [CHAN_W-1:0] ch_idx;
    logic              ch_ok;
    logic [CHAN_W-1:0] free_idx;
    logic              free_any;

    meta_t meta_rdata;
    meta_t meta_cur;
    meta_t meta_wdata;
    logic  meta_we;
    logic [CHAN_W-1:0] meta_raddr;

    logic [STORE_AW-1:0] store_base;
    logic                store_we;
    logic [STORE_AW-1:0] store_waddr;
    logic                store_re;
    logic [STORE_AW-1:0] store_raddr;
    logic [7:0]          store_rdata;

    status_t    exec_status;
    logic [3:0] exec_opened;
    logic       take_byte;

    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign exec_fire = (state_reg == S_EXEC) && out_free;
    assign byte_fire = (state_reg == S_BYTE) && out_free;

    assign meta_raddr = CHAN_W'(s_tdata[3:0]);
    assign ch_idx     = CHAN_W'(ch_reg);
    assign ch_ok      = ({3'b000, ch_reg} < 7'(CHAN_COUNT)) && open_reg[ch_idx];
    assign meta_cur   = meta_hit_reg ? meta_rdata : '0;
    assign store_base = STORE_AW'(ch_idx) * STORE_AW'(PIPE_BYTES);

    // Lowest free channel
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = CHAN_COUNT - 1; i >= 0; i--) begin
            if (!open_reg[i]) begin
                free_idx = CHAN_W'(i);
                free_any = 1'b1;
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = take_byte ? S_BYTE : S_IDLE;
                end
            end
            S_BYTE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Request decode and record update
    always_comb begin
        exec_status = ST_BAD;
        exec_opened = '0;
        take_byte   = 1'b0;
        meta_we     = 1'b0;
        meta_wdata  = meta_cur;
        store_we    = 1'b0;
        store_re    = 1'b0;
        store_waddr = store_base + STORE_AW'(meta_cur.wr_ptr);
        store_raddr = store_base + STORE_AW'(meta_cur.rd_ptr);
        open_next   = open_reg;
        mode_next   = mode_reg;
        mvld_next   = mvld_reg;
        s_tready    = (state_reg == S_IDLE);

        case (req_reg)
            REQ_OPEN: begin
                if (free_any) begin
                    exec_status = ST_OK;
                    exec_opened = 4'(free_idx);
                    if (exec_fire) begin
                        open_next[free_idx] = 1'b1;
                        mode_next[free_idx] = cons_reg;
                        mvld_next[free_idx] = 1'b0;
                    end
                end
            end
            REQ_CLOSE: begin
                if (ch_ok) begin
                    exec_status = ST_OK;
                    if (exec_fire) begin
                        open_next[ch_idx] = 1'b0;
                    end
                end
            end
            REQ_WRITE: begin
                if (ch_ok) begin
                    if (meta_cur.eof) begin
                        exec_status = ST_EOF;
                    end else if (meta_cur.fill >= FILL_W'(PIPE_BYTES)) begin
                        exec_status = ST_FULL;
                    end else begin
                        exec_status       = ST_OK;
                        meta_wdata.wr_ptr = ptr_advance(meta_cur.wr_ptr);
                        meta_wdata.fill   = meta_cur.fill + FILL_W'(1);
                        meta_we           = exec_fire;
                        store_we          = exec_fire;
                    end
                end
            end
            REQ_READ: begin
                if (ch_ok) begin
                    if (meta_cur.fill != '0) begin
                        exec_status       = ST_OK;
                        take_byte         = 1'b1;
                        meta_wdata.rd_ptr = ptr_advance(meta_cur.rd_ptr);
                        meta_wdata.fill   = meta_cur.fill - FILL_W'(1);
                        meta_we           = exec_fire;
                        store_re          = exec_fire;
                    end else if (!meta_cur.eof) begin
                        exec_status = ST_EMPTY;
                    end else if (first_reg) begin
                        exec_status = ST_EOF;
                        if (mode_reg[ch_idx]) begin
                            meta_wdata.eof = 1'b0;
                            meta_we        = exec_fire;
                        end
                    end else begin
                        exec_status = ST_ENDED;
                    end
                end
            end
            REQ_EOF: begin
                if (ch_ok) begin
                    exec_status    = ST_OK;
                    meta_wdata.eof = 1'b1;
                    meta_we        = exec_fire;
                end
            end
            default: exec_status = ST_BAD;
        endcase

        if (meta_we) begin
            mvld_next[ch_idx] = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            open_reg     <= CHAN_COUNT'(3);
            mode_reg     <= CHAN_COUNT'(3);
            mvld_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            open_reg  <= open_next;
            mode_reg  <= mode_next;
            mvld_reg  <= mvld_next;
            if (exec_fire && !take_byte) begin
                m_tvalid_reg <= 1'b1;
            end else if (byte_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Capture the item and load the result
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg      <= req_t'(s_tuser);
            ch_reg       <= s_tdata[3:0];
            wbyte_reg    <= s_tdata[11:4];
            cons_reg     <= s_tdata[12];
            first_reg    <= s_tdata[13];
            meta_hit_reg <= mvld_reg[meta_raddr];
        end
        if (exec_fire && !take_byte) begin
            status_reg <= exec_status;
            opened_reg <= exec_opened;
            rbyte_reg  <= '0;
        end else if (byte_fire) begin
            status_reg <= ST_OK;
            opened_reg <= '0;
            rbyte_reg  <= store_rdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {4'b0000, rbyte_reg, opened_reg};

    // Per-channel pointer records
    mcpf_ram #(
        .WIDTH ($bits(meta_t)),
        .DEPTH (CHAN_COUNT)
    ) u_meta_ram (
        .aclk    (aclk),
        .wr_en   (meta_we),
        .wr_addr (ch_idx),
        .wr_data (meta_wdata),
        .rd_en   (s_fire),
        .rd_addr (meta_raddr),
        .rd_data (meta_rdata)
    );

    // Byte store for all pipes
    mcpf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store_ram (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr (store_waddr),
        .wr_data (wbyte_reg),
        .rd_en   (store_re),
        .rd_addr (store_raddr),
        .rd_data (store_rdata)
    );

endmodule

[hdl/mcpf_checker.sv]
// ============================================================================
// mcpf_checker - port-level checks for the pipe FIFO
// Watches the stream ports of the top level; attached by bind.
// ============================================================================
`include "multi_channel_pipe_fifo_top_defines.svh"

module mcpf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [2:0]  m_tuser,
    input logic [15:0] m_tdata
);

    import mcpf_pkg::*;

    // Hold a stalled result
    `MCPF_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `MCPF_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

    // One item in work at a time
    `MCPF_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // Channel or byte payload only with an ok status
    `MCPF_ASSERT_IMPLY(a_payload_ok, aclk, aresetn, m_tvalid && (m_tdata[11:0] != 12'd0), m_tuser == ST_OK)

endmodule

bind multi_channel_pipe_fifo_top mcpf_checker u_mcpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

[test/tb_multi_channel_pipe_fifo_top.sv]
// ============================================================================
// tb_multi_channel_pipe_fifo_top - self-checking bench for the byte pipe bank
// Drives open, close, write, read and eof requests over the request stream
// and tracks every channel's ring, eof flag and mode in a scoreboard. Each
// reply is checked field by field against the predicted one. A directed
// opener covers the corner cases. The random sessions run under three
// flow-control profiles.
// ============================================================================
module tb_multi_channel_pipe_fifo_top;
    import mcpf_pkg::*;

    // Request codes the block does not define
    localparam bit [2:0] REQ_UNUSED_LO = 3'd5;
    localparam bit [2:0] REQ_UNUSED_HI = 3'd7;
    localparam int       RUN_LIMIT     = 1000000;
    localparam int       PHASE_ITEMS   = 200;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser  = '0;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [2:0]  m_tuser;
    logic [15:0] m_tdata;

    typedef struct {
        status_t  status;
        bit [3:0] opened;
        bit [7:0] data;
    } pipe_reply_t;

    // Scoreboard: shadow copy of every pipe plus the queue of replies owed
    class pipe_bank_checker;
        bit          is_open[CHAN_COUNT];
        bit          consumes_eof[CHAN_COUNT];
        bit          eof_set[CHAN_COUNT];
        int unsigned rd_idx[CHAN_COUNT];
        int unsigned wr_idx[CHAN_COUNT];
        int unsigned fill[CHAN_COUNT];
        bit [7:0]    ring[CHAN_COUNT][PIPE_BYTES];
        pipe_reply_t replies_due[$];
        int          mismatches;
        int          replies_checked;
        int          status_seen[8];

        function new();
            for (int c = 0; c < CHAN_COUNT; c++) begin
                is_open[c]      = 1'b0;
                consumes_eof[c] = 1'b0;
                eof_set[c]      = 1'b0;
                rd_idx[c]       = 0;
                wr_idx[c]       = 0;
                fill[c]         = 0;
            end
            mismatches      = 0;
            replies_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            open_channel(0, 1'b1);
            open_channel(1, 1'b1);
        endfunction

        function void open_channel(int c, bit consume);
            is_open[c]      = 1'b1;
            consumes_eof[c] = consume;
            eof_set[c]      = 1'b0;
            rd_idx[c]       = 0;
            wr_idx[c]       = 0;
            fill[c]         = 0;
        endfunction

        // Apply one accepted request and queue the reply it must produce
        function void note_request(bit [2:0] req, bit [3:0] ch, bit [7:0] data,
                                   bit consume, bit first_flag);
            pipe_reply_t r;
            r.status = ST_BAD;
            r.opened = '0;
            r.data   = '0;
            if (req == REQ_OPEN) begin
                for (int c = 0; c < CHAN_COUNT; c++) begin
                    if (!is_open[c]) begin
                        open_channel(c, consume);
                        r.status = ST_OK;
                        r.opened = 4'(c);
                        break;
                    end
                end
            end else if (is_open[ch]) begin
                case (req)
                    REQ_CLOSE: begin
                        is_open[ch] = 1'b0;
                        r.status    = ST_OK;
                    end
                    REQ_WRITE: begin
                        if (eof_set[ch]) begin
                            r.status = ST_EOF;
                        end else if (fill[ch] >= PIPE_BYTES) begin
                            r.status = ST_FULL;
                        end else begin
                            ring[ch][wr_idx[ch]] = data;
                            wr_idx[ch] = (wr_idx[ch] + 1) % PIPE_BYTES;
                            fill[ch]++;
                            r.status = ST_OK;
                        end
                    end
                    REQ_READ: begin
                        if (fill[ch] != 0) begin
                            r.data     = ring[ch][rd_idx[ch]];
                            rd_idx[ch] = (rd_idx[ch] + 1) % PIPE_BYTES;
                            fill[ch]--;
                            r.status   = ST_OK;
                        end else if (!eof_set[ch]) begin
                            r.status = ST_EMPTY;
                        end else if (first_flag) begin
                            if (consumes_eof[ch]) eof_set[ch] = 1'b0;
                            r.status = ST_EOF;
                        end else begin
                            r.status = ST_ENDED;
                        end
                    end
                    REQ_EOF: begin
                        eof_set[ch] = 1'b1;
                        r.status    = ST_OK;
                    end
                    default: r.status = ST_BAD;
                endcase
            end
            replies_due.push_back(r);
        endfunction

        // Compare one reply with the oldest one owed
        function void check_reply(logic [2:0] status, logic [3:0] opened, logic [7:0] data);
            pipe_reply_t want;
            if (replies_due.size() == 0) begin
                $error("reply with none outstanding: status %0d", status);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            replies_checked++;
            status_seen[want.status]++;
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                mismatches++;
            end
            if (opened !== want.opened) begin
                $error("opened_channel: expected %0d, actual %0d", want.opened, opened);
                mismatches++;
            end
            if (data !== want.data) begin
                $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, data);
                mismatches++;
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function int random_open_channel();
            int picks[$];
            for (int c = 0; c < CHAN_COUNT; c++) if (is_open[c]) picks.push_back(c);
            if (picks.size() == 0) return -1;
            return picks[$urandom_range(picks.size() - 1)];
        endfunction

        function int lowest_free_channel();
            for (int c = 0; c < CHAN_COUNT; c++) if (!is_open[c]) return c;
            return -1;
        endfunction
    endclass

    pipe_bank_checker bank;
    int send_idle_pct = 20;
    int recv_idle_pct = 81;
    int items_sent    = 0;

    multi_channel_pipe_fifo_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every reply item as it is taken
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            bank.check_reply(m_tuser, m_tdata[3:0], m_tdata[11:4]);
        end
    end

    // Offer one request item, idling first at random; entered and left at a falling edge
    task automatic send_req(input bit [2:0] req, input bit [3:0] ch, input bit [7:0] data,
                            input bit consume, input bit first_flag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, first_flag, consume, data, ch};
        do @(posedge aclk); while (!s_tready);
        bank.note_request(req, ch, data, consume, first_flag);
        items_sent++;
        @(negedge aclk);
    endtask

    // Hold off the sender until every owed reply has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (bank.pending() != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    // One read call: first byte flagged, the rest not
    task automatic read_call(input int ch, input int n);
        for (int i = 0; i < n; i++) begin
            send_req(REQ_READ, 4'(ch), 8'($urandom), 1'($urandom), i == 0);
        end
    endtask

    // One random session: mostly write/eof/read traffic on an open channel
    task automatic run_session();
        int ch;
        int n;
        int pick;
        bit [2:0] req;
        pick = $urandom_range(99);
        ch   = bank.random_open_channel();
        if (pick < 65 && ch >= 0) begin
            n = $urandom_range(12, 1);
            repeat (n) send_req(REQ_WRITE, 4'(ch), 8'($urandom), 1'($urandom), 1'($urandom));
            if ($urandom_range(1)) begin
                send_req(REQ_EOF, 4'(ch), 8'($urandom), 1'($urandom), 1'($urandom));
            end
            read_call(ch, $urandom_range(n + 3, 1));
            if ($urandom_range(3) == 0) read_call(ch, $urandom_range(4, 1));
            if ($urandom_range(6) == 0) begin
                send_req(REQ_CLOSE, 4'(ch), 8'($urandom), 1'($urandom), 1'($urandom));
                send_req(REQ_OPEN, 4'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end
        end else if (pick < 80) begin
            if (ch >= 0 && $urandom_range(1)) begin
                send_req(REQ_CLOSE, 4'(ch), 8'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                send_req(REQ_OPEN, 4'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end
        end else begin
            // Noise: any request on any channel, now and then an undefined code
            if ($urandom_range(19) == 0) begin
                req = 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
            end else begin
                req = 3'($urandom_range(REQ_EOF));
            end
            send_req(req, 4'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // Main sequence
    initial begin
        int start;
        bank = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty, data behind eof, sticky and consumed eof, closed channel
        send_req(REQ_READ,  4'd0,  8'h00, 1'b0, 1'b1);
        send_req(REQ_WRITE, 4'd0,  8'h00, 1'b0, 1'b0);
        send_req(REQ_WRITE, 4'd0,  8'hFF, 1'b1, 1'b1);
        send_req(REQ_EOF,   4'd0,  8'h00, 1'b0, 1'b0);
        send_req(REQ_EOF,   4'd0,  8'h00, 1'b0, 1'b0);
        send_req(REQ_WRITE, 4'd0,  8'hA5, 1'b0, 1'b0);
        send_req(REQ_READ,  4'd0,  8'h00, 1'b0, 1'b1);
        send_req(REQ_READ,  4'd0,  8'h00, 1'b0, 1'b0);
        send_req(REQ_READ,  4'd0,  8'h00, 1'b0, 1'b0);
        send_req(REQ_READ,  4'd0,  8'h00, 1'b0, 1'b1);
        send_req(REQ_READ,  4'd0,  8'h00, 1'b0, 1'b1);
        send_req(REQ_CLOSE, 4'd15, 8'h00, 1'b0, 1'b0);
        send_req(REQ_WRITE, 4'd15, 8'h5A, 1'b0, 1'b0);
        send_req(REQ_READ,  4'd15, 8'h00, 1'b0, 1'b1);
        send_req(REQ_EOF,   4'd15, 8'h00, 1'b0, 1'b0);
        for (int r = REQ_UNUSED_LO; r <= REQ_UNUSED_HI; r++) begin
            send_req(3'(r), 4'd0, 8'h00, 1'b0, 1'b0);
        end
        send_req(REQ_CLOSE, 4'd1,  8'h00, 1'b0, 1'b0);
        send_req(REQ_OPEN,  4'd0,  8'h00, 1'b0, 1'b0);
        send_req(REQ_EOF,   4'd1,  8'h00, 1'b0, 1'b0);
        send_req(REQ_READ,  4'd1,  8'h00, 1'b0, 1'b1);
        send_req(REQ_READ,  4'd1,  8'h00, 1'b0, 1'b1);
        // Open until none is free, ending on a refused open
        repeat (CHAN_COUNT - 1) send_req(REQ_OPEN, 4'($urandom), 8'($urandom), 1'($urandom), 1'b0);

        // Random sessions under three flow-control profiles
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 20; recv_idle_pct = 81; end
                1: begin send_idle_pct = 81; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) run_session();
            hold_until_drained();
        end

        repeat (16) @(negedge aclk);
        $display("Sent %0d request items: corner cases and random sessions.",
                 items_sent);
        $display("Replies checked %0d (ok %0d, bad %0d, full %0d, empty %0d, eof %0d, ended %0d)",
                 bank.replies_checked, bank.status_seen[ST_OK], bank.status_seen[ST_BAD],
                 bank.status_seen[ST_FULL], bank.status_seen[ST_EMPTY],
                 bank.status_seen[ST_EOF], bank.status_seen[ST_ENDED]);
        if (bank.mismatches == 0 && bank.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
